/* rtl/jpeg_marker_segment_parser_defines.svh */
// Assertion macros for the JPEG marker segment parser.
// Included by the top level; depends on a clock named clk and a reset named rst_n.
`ifndef JPEG_MARKER_SEGMENT_PARSER_DEFINES_SVH
`define JPEG_MARKER_SEGMENT_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define JMSP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jmsp: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define JMSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jmsp: next-cycle check failed");

`else

`define JMSP_ASSERT_SAME(label, ante, cons)
`define JMSP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/jmsp_pkg.sv */
// Package for the JPEG marker segment parser: walk phase type and marker codes.
// No dependencies.
package jmsp_pkg;

    typedef enum logic [7:0] {
        PH_SIG  = 8'b0000_0001,
        PH_SEEK = 8'b0000_0010,
        PH_MARK = 8'b0000_0100,
        PH_LENH = 8'b0000_1000,
        PH_LENL = 8'b0001_0000,
        PH_BODY = 8'b0010_0000,
        PH_STOP = 8'b0100_0000,
        PH_BAD  = 8'b1000_0000
    } phase_t;

    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] MRK_SOI  = 8'hD8;
    localparam logic [7:0] MRK_TEM  = 8'h01;
    localparam logic [7:0] MRK_RST0 = 8'hD0;
    localparam logic [7:0] MRK_RST7 = 8'hD7;
    localparam logic [7:0] MRK_EOI  = 8'hD9;
    localparam logic [7:0] MRK_SOS  = 8'hDA;
    localparam logic [7:0] MRK_SOF0 = 8'hC0;
    localparam logic [7:0] MRK_SOFF = 8'hCF;
    localparam logic [7:0] MRK_DHT  = 8'hC4;
    localparam logic [7:0] MRK_JPG  = 8'hC8;
    localparam logic [7:0] MRK_DAC  = 8'hCC;
    localparam logic [7:0] MRK_SOF2 = 8'hC2;
    localparam logic [7:0] MRK_APPE = 8'hEE;

    // Number of SOF data bytes needed before the dimensions count.
    localparam logic [2:0] SOF_MIN_BODY = 3'd5;

    // Start-of-frame markers: C0..CF apart from DHT, JPG and DAC.
    function automatic logic is_sof(input logic [7:0] m);
        return (m >= MRK_SOF0) && (m <= MRK_SOFF) && (m != MRK_DHT) &&
               (m != MRK_JPG) && (m != MRK_DAC);
    endfunction

endpackage

/* rtl/jpeg_marker_segment_parser.sv */
// JPEG marker segment parser: signature check, segment walk, SOF size capture.
// Depends on jmsp_pkg and jpeg_marker_segment_parser_defines.svh.
//
// Usage: the input channel carries one file byte per request (data_byte) with
// end_of_file marking the last byte of a file. Each accepted byte updates the
// walk state in the same cycle; there is no other pipeline stage. When the byte
// flagged end_of_file is accepted, one result request is loaded into the
// output register and out_valid rises on the next cycle. The block accepts one
// byte in every cycle while in_stall is low; the walk state registers are the
// only loop.
// The output register parts the two sides: bytes keep flowing while a result
// waits, and in_stall is raised only when a result is still held and out_stall
// is high, because the next end_of_file byte would have nowhere to go.
// While the receiver stalls, the result fields hold steady.
// Reset clears the walk state and the output valid flag; after each result
// the walk state returns to its reset values so the next byte starts a new file.
// TAIL_WINDOW sets the tail search: the D9 of the FF D9 pair must lie in the last TAIL_WINDOW - 1 bytes.

`include "jpeg_marker_segment_parser_defines.svh"

module jpeg_marker_segment_parser
    import jmsp_pkg::*;
#(
    parameter int TAIL_WINDOW = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_file,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        signature_ok,
    output logic [15:0] jpeg_width,
    output logic [15:0] jpeg_height,
    output logic        size_missing,
    output logic        is_progressive,
    output logic        adobe_marker,
    output logic        eoi_found
);

    // The EOI age saturates at TAIL_WINDOW, which already means "outside the window".
    localparam int               AGE_W   = $clog2(TAIL_WINDOW + 1);
    localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(TAIL_WINDOW);

    // Walk state.
    phase_t            phase_reg,      phase_next;
    logic [1:0]        sig_count_reg,  sig_count_next;
    logic [7:0]        marker_reg,     marker_next;
    logic [15:0]       bytes_left_reg, bytes_left_next;
    logic [2:0]        body_idx_reg,   body_idx_next;
    logic [15:0]       pend_w_reg,     pend_w_next;
    logic [15:0]       pend_h_reg,     pend_h_next;
    logic [15:0]       comm_w_reg,     comm_w_next;
    logic [15:0]       comm_h_reg,     comm_h_next;
    logic              prog_reg,       prog_next;
    logic              adobe_reg,      adobe_next;
    logic              ff_before_reg,  ff_before_next;
    logic [AGE_W-1:0]  eoi_age_reg,    eoi_age_next;

    // Result register.
    logic              res_valid_reg;
    logic              res_ok_reg,     res_ok_next;
    logic [15:0]       res_w_reg,      res_w_next;
    logic [15:0]       res_h_reg,      res_h_next;
    logic              res_miss_reg,   res_miss_next;
    logic              res_prog_reg,   res_prog_next;
    logic              res_adobe_reg,  res_adobe_next;
    logic              res_eoi_reg,    res_eoi_next;
    logic              res_load;

    logic              in_accept;

    // A new byte is refused only when a finished result is stuck in the output register.
    assign in_stall  = res_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;

    always_comb
    begin
        logic        seg_done;
        logic [15:0] seg_len;
        logic        file_ok;

        seg_done        = 1'b0;
        seg_len         = {bytes_left_reg[7:0], data_byte};
        file_ok         = 1'b0;

        phase_next      = phase_reg;
        sig_count_next  = sig_count_reg;
        marker_next     = marker_reg;
        bytes_left_next = bytes_left_reg;
        body_idx_next   = body_idx_reg;
        pend_w_next     = pend_w_reg;
        pend_h_next     = pend_h_reg;
        comm_w_next     = comm_w_reg;
        comm_h_next     = comm_h_reg;
        prog_next       = prog_reg;
        adobe_next      = adobe_reg;
        ff_before_next  = ff_before_reg;
        eoi_age_next    = eoi_age_reg;

        res_load        = 1'b0;
        res_ok_next     = res_ok_reg;
        res_w_next      = res_w_reg;
        res_h_next      = res_h_reg;
        res_miss_next   = res_miss_reg;
        res_prog_next   = res_prog_reg;
        res_adobe_next  = res_adobe_reg;
        res_eoi_next    = res_eoi_reg;

        if (in_accept)
        begin
            // Tail tracker: age counts bytes since the D9 of the latest FF D9 pair.
            if (eoi_age_reg < AGE_MAX)
            begin
                eoi_age_next = eoi_age_reg + AGE_W'(1);
            end
            if (ff_before_reg && (data_byte == MRK_EOI))
            begin
                eoi_age_next = AGE_W'(1);
            end
            ff_before_next = (data_byte == BYTE_FF);

            case (phase_reg)
                PH_SIG:
                begin
                    if (data_byte != ((sig_count_reg == 2'd1) ? MRK_SOI : BYTE_FF))
                    begin
                        phase_next = PH_BAD;
                    end
                    else if (sig_count_reg >= 2'd2)
                    begin
                        // The third signature byte doubles as the first marker's FF.
                        phase_next = PH_MARK;
                    end
                    else
                    begin
                        sig_count_next = sig_count_reg + 2'd1;
                    end
                end
                PH_SEEK:
                begin
                    if (data_byte == BYTE_FF)
                    begin
                        phase_next = PH_MARK;
                    end
                end
                PH_MARK:
                begin
                    if (data_byte == BYTE_FF)
                    begin
                        phase_next = PH_MARK;
                    end
                    else if ((data_byte == MRK_SOI) || (data_byte == MRK_TEM) ||
                             ((data_byte >= MRK_RST0) && (data_byte <= MRK_RST7)))
                    begin
                        phase_next = PH_SEEK;
                    end
                    else if ((data_byte == MRK_EOI) || (data_byte == MRK_SOS))
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        marker_next = data_byte;
                        phase_next  = PH_LENH;
                    end
                end
                PH_LENH:
                begin
                    bytes_left_next = {8'd0, data_byte};
                    phase_next      = PH_LENL;
                end
                PH_LENL:
                begin
                    if (seg_len < 16'd2)
                    begin
                        phase_next = PH_STOP;
                    end
                    else
                    begin
                        bytes_left_next = seg_len - 16'd2;
                        body_idx_next   = 3'd0;
                        pend_w_next     = 16'd0;
                        pend_h_next     = 16'd0;
                        if (seg_len == 16'd2)
                        begin
                            seg_done = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_BODY;
                        end
                    end
                end
                PH_BODY:
                begin
                    case (body_idx_reg)
                        3'd1:    pend_h_next = {data_byte, 8'd0};
                        3'd2:    pend_h_next = {pend_h_reg[15:8], data_byte};
                        3'd3:    pend_w_next = {data_byte, 8'd0};
                        3'd4:    pend_w_next = {pend_w_reg[15:8], data_byte};
                        default: ;
                    endcase
                    if (body_idx_reg < SOF_MIN_BODY)
                    begin
                        body_idx_next = body_idx_reg + 3'd1;
                    end
                    bytes_left_next = bytes_left_reg - 16'd1;
                    if (bytes_left_reg == 16'd1)
                    begin
                        seg_done = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            // A segment counts only once its last data byte has arrived.
            if (seg_done)
            begin
                if (is_sof(marker_reg) && (body_idx_next >= SOF_MIN_BODY))
                begin
                    comm_w_next = pend_w_next;
                    comm_h_next = pend_h_next;
                    if (marker_reg == MRK_SOF2)
                    begin
                        prog_next = 1'b1;
                    end
                end
                else if (marker_reg == MRK_APPE)
                begin
                    adobe_next = 1'b1;
                end
                phase_next = PH_SEEK;
            end

            if (end_of_file)
            begin
                file_ok        = (phase_next != PH_BAD) && (phase_next != PH_SIG);
                res_load       = 1'b1;
                res_ok_next    = file_ok;
                res_w_next     = file_ok ? comm_w_next : 16'd0;
                res_h_next     = file_ok ? comm_h_next : 16'd0;
                res_miss_next  = !file_ok || (comm_w_next == 16'd0) || (comm_h_next == 16'd0);
                res_prog_next  = file_ok && prog_next;
                res_adobe_next = file_ok && adobe_next;
                res_eoi_next   = file_ok && (eoi_age_next < AGE_MAX);

                // Back to the reset state for the next file.
                phase_next      = PH_SIG;
                sig_count_next  = 2'd0;
                marker_next     = 8'd0;
                bytes_left_next = 16'd0;
                body_idx_next   = 3'd0;
                pend_w_next     = 16'd0;
                pend_h_next     = 16'd0;
                comm_w_next     = 16'd0;
                comm_h_next     = 16'd0;
                prog_next       = 1'b0;
                adobe_next      = 1'b0;
                ff_before_next  = 1'b0;
                eoi_age_next    = AGE_MAX;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIG;
            sig_count_reg  <= 2'd0;
            marker_reg     <= 8'd0;
            bytes_left_reg <= 16'd0;
            body_idx_reg   <= 3'd0;
            pend_w_reg     <= 16'd0;
            pend_h_reg     <= 16'd0;
            comm_w_reg     <= 16'd0;
            comm_h_reg     <= 16'd0;
            prog_reg       <= 1'b0;
            adobe_reg      <= 1'b0;
            ff_before_reg  <= 1'b0;
            eoi_age_reg    <= AGE_MAX;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            sig_count_reg  <= sig_count_next;
            marker_reg     <= marker_next;
            bytes_left_reg <= bytes_left_next;
            body_idx_reg   <= body_idx_next;
            pend_w_reg     <= pend_w_next;
            pend_h_reg     <= pend_h_next;
            comm_w_reg     <= comm_w_next;
            comm_h_reg     <= comm_h_next;
            prog_reg       <= prog_next;
            adobe_reg      <= adobe_next;
            ff_before_reg  <= ff_before_next;
            eoi_age_reg    <= eoi_age_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload; it only changes when a new result is loaded.
    always_ff @(posedge clk)
    begin
        res_ok_reg    <= res_ok_next;
        res_w_reg     <= res_w_next;
        res_h_reg     <= res_h_next;
        res_miss_reg  <= res_miss_next;
        res_prog_reg  <= res_prog_next;
        res_adobe_reg <= res_adobe_next;
        res_eoi_reg   <= res_eoi_next;
    end

    assign out_valid      = res_valid_reg;
    assign signature_ok   = res_ok_reg;
    assign jpeg_width     = res_w_reg;
    assign jpeg_height    = res_h_reg;
    assign size_missing   = res_miss_reg;
    assign is_progressive = res_prog_reg;
    assign adobe_marker   = res_adobe_reg;
    assign eoi_found      = res_eoi_reg;

    // The last byte of a file always produces a result on the next cycle.
    `JMSP_ASSERT_NEXT(a_eof_gives_result, in_accept && end_of_file, out_valid)
    // A taken result disappears unless another file ended in the same cycle.
    `JMSP_ASSERT_NEXT(a_result_drains,
        out_valid && !out_stall && !(in_accept && end_of_file), !out_valid)
    // The size flag agrees with the reported dimensions.
    `JMSP_ASSERT_SAME(a_size_flag,
        out_valid, size_missing == ((jpeg_width == 16'd0) || (jpeg_height == 16'd0)))
    // A file without the signature reports nothing else.
    `JMSP_ASSERT_SAME(a_bad_sig_clean, out_valid && !signature_ok,
        !eoi_found && !is_progressive && !adobe_marker && (jpeg_width == 16'd0))

endmodule
